[rtl/touch_event_assembler_scaler_defines.svh]
// Assertion macros for the touch event assembler and scaler.
`ifndef TOUCH_EVENT_ASSEMBLER_SCALER_DEFINES_SVH
`define TOUCH_EVENT_ASSEMBLER_SCALER_DEFINES_SVH

// Same-cycle implication, checked on clk_i and disabled during reset.
`define TEAS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and disabled during reset.
`define TEAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/teas_pkg.sv]
// Shared constants, types and state encodings of the touch event assembler and scaler.
package teas_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned EVENT_BITS = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(COORD_BITS + 1);

  localparam logic [4:0] EV_TYPE_KEY    = 5'd1;
  localparam logic [4:0] EV_TYPE_ABS    = 5'd3;
  localparam logic [9:0] TOUCH_KEY_CODE = 10'd330;
  localparam logic [9:0] AXIS_X_CODE    = 10'd0;
  localparam logic [9:0] AXIS_Y_CODE    = 10'd1;
  localparam logic [9:0] AXIS_P_CODE    = 10'd24;

  localparam int unsigned FLAG_START = 0;
  localparam int unsigned FLAG_X     = 1;
  localparam int unsigned FLAG_Y     = 2;
  localparam int unsigned FLAG_P     = 3;
  localparam int unsigned FLAG_CNT   = 4;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_H  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE   = 3'd4;

  localparam logic [COORD_BITS-1:0] RST_SCREEN_W = 16'd1024;
  localparam logic [COORD_BITS-1:0] RST_SCREEN_H = 16'd600;
  localparam logic [COORD_BITS-1:0] RST_TOUCH_W  = 16'd800;
  localparam logic [COORD_BITS-1:0] RST_TOUCH_H  = 16'd480;
  localparam logic [1:0]            ROTATE_NONE   = 2'd0;
  localparam logic [1:0]            ROTATE_MIRROR = 2'd1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] pressure;
    logic                  kind;
  } job_t;

  typedef struct packed {
    logic start;
    logic mirror;
    logic both_eq;
    logic both_gt;
  } axis_ctrl_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  typedef enum logic [2:0] {
    AX_IDLE,
    AX_DIV_ST,
    AX_DIV_VW,
    AX_MUL,
    AX_DIV_PT,
    AX_DONE
  } axis_state_e;

endpackage

[rtl/teas_div.sv]
// Restoring divider that retires one quotient bit per cycle; the quotient must fit in COORD_BITS.
module teas_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [2*teas_pkg::COORD_BITS-1:0]     dividend_i,
  input  logic [teas_pkg::COORD_BITS-1:0]       divisor_i,
  output logic                                  done_o,
  output logic [teas_pkg::COORD_BITS-1:0]       quot_o,
  output logic [teas_pkg::COORD_BITS-1:0]       rem_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [teas_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic [teas_pkg::COORD_BITS-1:0]     rem_q, rem_d;
  logic [teas_pkg::COORD_BITS-1:0]     quo_q;
  logic [teas_pkg::COORD_BITS-1:0]     dvs_q;
  logic [teas_pkg::COORD_BITS:0]       trial;
  logic [teas_pkg::COORD_BITS:0]       diff;
  logic                                qbit;

  always_comb begin
    trial = {rem_q, quo_q[teas_pkg::COORD_BITS-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? diff[teas_pkg::COORD_BITS-1:0] : trial[teas_pkg::COORD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= teas_pkg::DIV_CNT_W'(teas_pkg::COORD_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == teas_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The upper half of the dividend is below the divisor, so it seeds the partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[2*teas_pkg::COORD_BITS-1:teas_pkg::COORD_BITS];
      quo_q <= dividend_i[teas_pkg::COORD_BITS-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[teas_pkg::COORD_BITS-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[rtl/teas_axis.sv]
// Per-axis mirror and touch-to-screen scaling unit built around its own serial divider, used for every division.
module teas_axis (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  teas_pkg::axis_ctrl_t            ctrl_i,
  input  logic [teas_pkg::COORD_BITS-1:0] coord_i,
  input  logic [teas_pkg::COORD_BITS-1:0] scr_i,
  input  logic [teas_pkg::COORD_BITS-1:0] tch_i,
  output logic                            done_o,
  output logic [teas_pkg::COORD_BITS-1:0] coord_o
);

  teas_pkg::axis_state_e state_q, state_d;

  logic [teas_pkg::COORD_BITS-1:0]   v_q, t_q, rem_q, opnd_q, res_q;
  logic                              gt_q;
  logic [teas_pkg::COORD_BITS-1:0]   v_mirr;
  logic                              pass;
  logic                              can_start;

  logic                              div_start;
  logic [2*teas_pkg::COORD_BITS-1:0] div_dividend;
  logic [teas_pkg::COORD_BITS-1:0]   div_divisor;
  logic                              div_done;
  logic [teas_pkg::COORD_BITS-1:0]   div_quot;
  logic [teas_pkg::COORD_BITS-1:0]   div_rem;
  logic [teas_pkg::COORD_BITS:0]     fin_sum;
  logic [teas_pkg::COORD_BITS-1:0]   fin_sat;

  teas_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    if (ctrl_i.mirror) begin
      v_mirr = (tch_i > coord_i) ? (tch_i - coord_i) : '0;
    end else begin
      v_mirr = coord_i;
    end
    pass      = (tch_i == '0) || ctrl_i.both_eq;
    can_start = (state_q == teas_pkg::AX_IDLE) || (state_q == teas_pkg::AX_DONE);
    // The fraction never exceeds the coordinate, so one extra bit covers the sum.
    if (gt_q) begin
      fin_sum = {1'b0, v_q} + {1'b0, div_quot};
    end else begin
      fin_sum = {1'b0, v_q} - {1'b0, div_quot};
    end
    fin_sat = fin_sum[teas_pkg::COORD_BITS] ? '1 : fin_sum[teas_pkg::COORD_BITS-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      teas_pkg::AX_IDLE, teas_pkg::AX_DONE: begin
        if (ctrl_i.start) begin
          state_d = pass ? teas_pkg::AX_DONE : teas_pkg::AX_DIV_ST;
        end
      end
      teas_pkg::AX_DIV_ST: begin
        if (div_done) begin
          state_d = gt_q ? teas_pkg::AX_DIV_VW : teas_pkg::AX_MUL;
        end
      end
      teas_pkg::AX_DIV_VW: begin
        if (div_done) begin
          state_d = teas_pkg::AX_MUL;
        end
      end
      teas_pkg::AX_MUL: begin
        state_d = teas_pkg::AX_DIV_PT;
      end
      teas_pkg::AX_DIV_PT: begin
        if (div_done) begin
          state_d = teas_pkg::AX_DONE;
        end
      end
      default: begin
        state_d = teas_pkg::AX_IDLE;
      end
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = t_q;
    case (state_q)
      teas_pkg::AX_IDLE, teas_pkg::AX_DONE: begin
        if (ctrl_i.start && !pass) begin
          div_start    = 1'b1;
          div_dividend = {{teas_pkg::COORD_BITS{1'b0}}, scr_i};
          div_divisor  = tch_i;
        end
      end
      teas_pkg::AX_DIV_ST: begin
        // Both sides larger: divide the coordinate by the whole ratio first.
        if (div_done && gt_q) begin
          div_start    = 1'b1;
          div_dividend = {{teas_pkg::COORD_BITS{1'b0}}, v_q};
          div_divisor  = div_quot;
        end
      end
      teas_pkg::AX_MUL: begin
        div_start    = 1'b1;
        div_dividend = opnd_q * rem_q;
        div_divisor  = t_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= teas_pkg::AX_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_start && ctrl_i.start) begin
      v_q   <= v_mirr;
      t_q   <= tch_i;
      gt_q  <= ctrl_i.both_gt;
      res_q <= v_mirr;
    end
    if ((state_q == teas_pkg::AX_DIV_ST) && div_done) begin
      rem_q  <= div_rem;
      opnd_q <= v_q;
    end
    if ((state_q == teas_pkg::AX_DIV_VW) && div_done) begin
      opnd_q <= div_quot;
    end
    if ((state_q == teas_pkg::AX_DIV_PT) && div_done) begin
      res_q <= fin_sat;
    end
  end

  assign done_o  = (state_q == teas_pkg::AX_DONE);
  assign coord_o = res_q;

endmodule

[rtl/teas_fifo.sv]
// Short word queue between the event front end and the scaling back end.
module teas_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  teas_pkg::job_t push_data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output teas_pkg::job_t pop_data_o
);

  teas_pkg::job_t                mem_q [teas_pkg::QUEUE_DEPTH];
  logic [teas_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [teas_pkg::QUEUE_AW:0]   cnt_q;
  logic                          do_push, do_pop;

  assign ready_o    = (cnt_q != (teas_pkg::QUEUE_AW+1)'(teas_pkg::QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == teas_pkg::QUEUE_AW'(teas_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == teas_pkg::QUEUE_AW'(teas_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/teas_front.sv]
// Event classifier: tracks touch state, latches axis values and emits sample and release words.
module teas_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [4:0]                             event_type_i,
  input  logic [9:0]                             event_code_i,
  input  logic signed [teas_pkg::EVENT_BITS-1:0] event_value_i,
  input  logic                                   q_ready_i,
  output logic                                   push_o,
  output teas_pkg::job_t                         job_o
);

  logic [teas_pkg::FLAG_CNT-1:0]   seen_q, seen_d;
  logic [teas_pkg::COORD_BITS-1:0] x_q, x_d, y_q, y_d, p_q, p_d;
  logic                            accept;
  logic                            positive;
  logic                            release_hit;
  logic [teas_pkg::COORD_BITS-1:0] latched;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  always_comb begin
    seen_d      = seen_q;
    x_d         = x_q;
    y_d         = y_q;
    p_d         = p_q;
    push_o      = 1'b0;
    release_hit = 1'b0;
    job_o       = '{x: x_q, y: y_q, pressure: p_q, kind: teas_pkg::KIND_RELEASE};
    positive    = !event_value_i[teas_pkg::EVENT_BITS-1] && (event_value_i != '0);
    latched     = (|event_value_i[teas_pkg::EVENT_BITS-1:teas_pkg::COORD_BITS]) ?
                  '1 : event_value_i[teas_pkg::COORD_BITS-1:0];
    if (accept) begin
      if ((event_type_i == teas_pkg::EV_TYPE_KEY) &&
          (event_code_i == teas_pkg::TOUCH_KEY_CODE)) begin
        if (event_value_i == 32'sd1) begin
          seen_d[teas_pkg::FLAG_START] = 1'b1;
        end else if (event_value_i == '0) begin
          // Touch-up reports the held values, then forgets them.
          release_hit = 1'b1;
          push_o      = 1'b1;
          seen_d      = '0;
          x_d         = '0;
          y_d         = '0;
          p_d         = '0;
        end
      end else if ((event_type_i == teas_pkg::EV_TYPE_ABS) && positive) begin
        case (event_code_i)
          teas_pkg::AXIS_X_CODE: begin
            x_d                      = latched;
            seen_d[teas_pkg::FLAG_X] = 1'b1;
          end
          teas_pkg::AXIS_Y_CODE: begin
            y_d                      = latched;
            seen_d[teas_pkg::FLAG_Y] = 1'b1;
          end
          teas_pkg::AXIS_P_CODE: begin
            p_d                      = latched;
            seen_d[teas_pkg::FLAG_P] = 1'b1;
          end
          default: begin
            seen_d = seen_q;
          end
        endcase
      end
      if (!release_hit && (seen_d == '1)) begin
        push_o = 1'b1;
        job_o  = '{x: x_d, y: y_d, pressure: p_d, kind: teas_pkg::KIND_SAMPLE};
        seen_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      p_q    <= '0;
    end else begin
      seen_q <= seen_d;
      x_q    <= x_d;
      y_q    <= y_d;
      p_q    <= p_d;
    end
  end

endmodule

[rtl/touch_event_assembler_scaler.sv]
// Top level: configuration registers, front end, word queue and scaling back end.
//
//   channel   handshake                   payload
//   cfg       cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//   in        in_valid_i / in_ready_o     event_type_i, event_code_i, event_value_i
//   out       out_valid_o / out_ready_i   x_out_o, y_out_o, pressure_out_o, sample_kind_o
//
// Events are taken one per cycle while the two-word queue has room. When both screen
// sides are larger, each axis unit runs three divisions per sample or release (ratio,
// coordinate by whole ratio, fraction), otherwise two, and none when scaling is
// bypassed. The axes run in parallel.
// Reset clears the touch state and loads the default resolutions; no clearing pass.
// A stalled output holds its word while the queue keeps taking events until it is full.
module touch_event_assembler_scaler (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [teas_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [teas_pkg::COORD_BITS-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [4:0]                             event_type_i,
  input  logic [9:0]                             event_code_i,
  input  logic signed [teas_pkg::EVENT_BITS-1:0] event_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [teas_pkg::COORD_BITS-1:0]        x_out_o,
  output logic [teas_pkg::COORD_BITS-1:0]        y_out_o,
  output logic [teas_pkg::COORD_BITS-1:0]        pressure_out_o,
  output logic                                   sample_kind_o
);

  `include "touch_event_assembler_scaler_defines.svh"

  logic [teas_pkg::COORD_BITS-1:0] scr_w_q, scr_h_q, tch_w_q, tch_h_q;
  logic [1:0]                      rotate_q;

  logic                 q_push, q_ready, q_pop, q_valid;
  teas_pkg::job_t       push_job, head_job;

  teas_pkg::back_state_e           bk_state_q, bk_state_d;
  teas_pkg::axis_ctrl_t            ax_ctrl;
  logic                            x_done, y_done;
  logic [teas_pkg::COORD_BITS-1:0] x_res, y_res;
  logic [teas_pkg::COORD_BITS-1:0] job_p_q;
  logic                            job_kind_q;
  logic                            out_free, out_load;

  logic                            out_valid_q;
  logic [teas_pkg::COORD_BITS-1:0] x_out_q, y_out_q, p_out_q;
  logic                            kind_out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q  <= teas_pkg::RST_SCREEN_W;
      scr_h_q  <= teas_pkg::RST_SCREEN_H;
      tch_w_q  <= teas_pkg::RST_TOUCH_W;
      tch_h_q  <= teas_pkg::RST_TOUCH_H;
      rotate_q <= teas_pkg::ROTATE_NONE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        teas_pkg::REG_SCREEN_W: scr_w_q  <= cfg_data_i;
        teas_pkg::REG_SCREEN_H: scr_h_q  <= cfg_data_i;
        teas_pkg::REG_TOUCH_W:  tch_w_q  <= cfg_data_i;
        teas_pkg::REG_TOUCH_H:  tch_h_q  <= cfg_data_i;
        teas_pkg::REG_ROTATE:   rotate_q <= cfg_data_i[1:0];
        default: begin
          rotate_q <= rotate_q;
        end
      endcase
    end
  end

  teas_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .event_type_i  (event_type_i),
    .event_code_i  (event_code_i),
    .event_value_i (event_value_i),
    .q_ready_i     (q_ready),
    .push_o        (q_push),
    .job_o         (push_job)
  );

  teas_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_job),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (head_job)
  );

  always_comb begin
    ax_ctrl.start   = q_pop;
    ax_ctrl.mirror  = (rotate_q == teas_pkg::ROTATE_MIRROR);
    ax_ctrl.both_eq = (scr_w_q == tch_w_q) && (scr_h_q == tch_h_q);
    ax_ctrl.both_gt = (scr_w_q > tch_w_q) && (scr_h_q > tch_h_q);
  end

  teas_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ax_ctrl),
    .coord_i (head_job.x),
    .scr_i   (scr_w_q),
    .tch_i   (tch_w_q),
    .done_o  (x_done),
    .coord_o (x_res)
  );

  teas_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ax_ctrl),
    .coord_i (head_job.y),
    .scr_i   (scr_h_q),
    .tch_i   (tch_h_q),
    .done_o  (y_done),
    .coord_o (y_res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    bk_state_d = bk_state_q;
    case (bk_state_q)
      teas_pkg::BK_IDLE: begin
        if (q_valid) begin
          bk_state_d = teas_pkg::BK_RUN;
        end
      end
      teas_pkg::BK_RUN: begin
        if (x_done && y_done && out_free) begin
          bk_state_d = teas_pkg::BK_IDLE;
        end
      end
      default: begin
        bk_state_d = teas_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (bk_state_q)
      teas_pkg::BK_IDLE: q_pop    = q_valid;
      teas_pkg::BK_RUN:  out_load = x_done && y_done && out_free;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bk_state_q  <= teas_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      bk_state_q <= bk_state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop) begin
      job_p_q    <= head_job.pressure;
      job_kind_q <= head_job.kind;
    end
    if (out_load) begin
      x_out_q    <= x_res;
      y_out_q    <= y_res;
      p_out_q    <= job_p_q;
      kind_out_q <= job_kind_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign x_out_o        = x_out_q;
  assign y_out_o        = y_out_q;
  assign pressure_out_o = p_out_q;
  assign sample_kind_o  = kind_out_q;

  `TEAS_ASSERT_IMPL(a_out_after_axes, $rose(out_valid_o), $past(x_done && y_done), "early word")
  `TEAS_ASSERT_NEXT(a_load_shows, out_load, out_valid_o, "finished word not loaded")
  `TEAS_ASSERT_NEXT(a_push_kept, q_push && !q_pop, q_valid, "queued word was lost")

endmodule

[verif/tb_touch_event_assembler_scaler.sv]
// Self-checking testbench for the touch event assembler and scaler.
module tb_touch_event_assembler_scaler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned IDLE_LIMIT      = 3000;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned PRESSURE_PHASE  = 5;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam longint unsigned COORD_MAX   = (64'd1 << teas_pkg::COORD_BITS) - 1;

  localparam logic [4:0] EV_TYPE_SYN      = 5'd0;
  localparam logic [9:0] AXIS_UNUSED_CODE = 10'd2;
  localparam logic [1:0] ROTATE_SPARE2    = 2'd2;
  localparam logic [1:0] ROTATE_SPARE3    = 2'd3;

  typedef enum logic {ROW_EVENT, ROW_CONFIG} row_kind_e;

  typedef struct packed {
    row_kind_e                       kind;
    logic [4:0]                      ev_type;
    logic [9:0]                      ev_code;
    logic [31:0]                     ev_value;
    logic [teas_pkg::COORD_BITS-1:0] sw;
    logic [teas_pkg::COORD_BITS-1:0] sh;
    logic [teas_pkg::COORD_BITS-1:0] tw;
    logic [teas_pkg::COORD_BITS-1:0] th;
    logic [1:0]                      rot;
    logic                            typed;
    teas_pkg::job_t                  want;
  } stim_row_t;

  logic                                   clk_i;
  logic                                   rst_ni;
  logic                                   cfg_valid_i;
  logic                                   cfg_ready_o;
  logic [teas_pkg::CFG_IDX_W-1:0]         cfg_index_i;
  logic [teas_pkg::COORD_BITS-1:0]        cfg_data_i;
  logic                                   in_valid_i;
  logic                                   in_ready_o;
  logic [4:0]                             event_type_i;
  logic [9:0]                             event_code_i;
  logic signed [teas_pkg::EVENT_BITS-1:0] event_value_i;
  logic                                   out_valid_o;
  logic                                   out_ready_i;
  logic [teas_pkg::COORD_BITS-1:0]        x_out_o;
  logic [teas_pkg::COORD_BITS-1:0]        y_out_o;
  logic [teas_pkg::COORD_BITS-1:0]        pressure_out_o;
  logic                                   sample_kind_o;

  // Predictor copy of the registers and the touch state.
  logic [teas_pkg::COORD_BITS-1:0] scr_w, scr_h, tch_w, tch_h;
  logic [1:0]                      rot_mode;
  logic [teas_pkg::FLAG_CNT-1:0]   seen;
  logic [teas_pkg::COORD_BITS-1:0] lat_x, lat_y, lat_p;

  teas_pkg::job_t pending_samples[$];
  stim_row_t      stim_table[$];
  int unsigned    n_mismatch;
  int unsigned    n_effective;
  int unsigned    idle_cycles;
  bit             quiet;
  bit             hold_req;

  touch_event_assembler_scaler u_top (.*);

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [teas_pkg::COORD_BITS-1:0] scale_coord(
      input logic [teas_pkg::COORD_BITS-1:0] v,
      input logic [teas_pkg::COORD_BITS-1:0] s, input logic [teas_pkg::COORD_BITS-1:0] t,
      input bit both_gt, input bit both_eq);
    longint unsigned a, sz, tz, whole;
    a  = 64'(v);
    sz = 64'(s);
    tz = 64'(t);
    if (rot_mode == teas_pkg::ROTATE_MIRROR) a = (tz > a) ? tz - a : 64'd0;
    if (tz != 0 && !both_eq) begin
      if (both_gt) begin
        whole = sz / tz;
        a = a + ((a / whole) * (sz % tz)) / tz;
      end else begin
        a = a - (a * (sz % tz)) / tz;
      end
    end
    if (a > COORD_MAX) a = COORD_MAX;
    return a[teas_pkg::COORD_BITS-1:0];
  endfunction

  function automatic teas_pkg::job_t build_sample(input logic kind);
    bit             gt, eq;
    teas_pkg::job_t j;
    eq = (scr_w == tch_w) && (scr_h == tch_h);
    gt = (scr_w > tch_w) && (scr_h > tch_h);
    j.x        = scale_coord(lat_x, scr_w, tch_w, gt, eq);
    j.y        = scale_coord(lat_y, scr_h, tch_h, gt, eq);
    j.pressure = lat_p;
    j.kind     = kind;
    return j;
  endfunction

  // Advances the touch state by one event; returns 1 when the event yields a word.
  function automatic bit touch_predict(input logic [4:0] ev_type, input logic [9:0] ev_code,
      input logic [31:0] ev_value, output teas_pkg::job_t res);
    logic [teas_pkg::COORD_BITS-1:0] held;
    held = (ev_value > COORD_MAX) ? COORD_MAX[teas_pkg::COORD_BITS-1:0] :
           ev_value[teas_pkg::COORD_BITS-1:0];
    res  = '0;
    if (ev_type == teas_pkg::EV_TYPE_KEY && ev_code == teas_pkg::TOUCH_KEY_CODE) begin
      if (ev_value == 32'd1) begin
        seen[teas_pkg::FLAG_START] = 1'b1;
        n_effective++;
      end else if (ev_value == 32'd0) begin
        res   = build_sample(teas_pkg::KIND_RELEASE);
        seen  = '0;
        lat_x = '0;
        lat_y = '0;
        lat_p = '0;
        n_effective++;
        return 1'b1;
      end
    end else if (ev_type == teas_pkg::EV_TYPE_ABS && !ev_value[31] && ev_value != 32'd0) begin
      case (ev_code)
        teas_pkg::AXIS_X_CODE: begin
          lat_x = held;
          seen[teas_pkg::FLAG_X] = 1'b1;
          n_effective++;
        end
        teas_pkg::AXIS_Y_CODE: begin
          lat_y = held;
          seen[teas_pkg::FLAG_Y] = 1'b1;
          n_effective++;
        end
        teas_pkg::AXIS_P_CODE: begin
          lat_p = held;
          seen[teas_pkg::FLAG_P] = 1'b1;
          n_effective++;
        end
        default: ;
      endcase
    end
    if (&seen) begin
      res  = build_sample(teas_pkg::KIND_SAMPLE);
      seen = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] axis_value(input logic [9:0] code);
    longint unsigned lim;
    int unsigned     r;
    if (code == teas_pkg::AXIS_X_CODE) lim = 64'(tch_w);
    else if (code == teas_pkg::AXIS_Y_CODE) lim = 64'(tch_h);
    else lim = COORD_MAX;
    lim = lim + lim / 4 + 1;
    if (lim > COORD_MAX) lim = COORD_MAX;
    r = $urandom_range(0, 15);
    case (r)
      0: return $urandom;
      1: return $urandom_range(32'h7FFF_FFFF, 32'h0001_0000);
      2: return COORD_MAX[31:0];
      3: return 32'd1;
      default: return $urandom_range(1, lim[31:0]);
    endcase
  endfunction

  function automatic void add_event(input logic [4:0] ev_type, input logic [9:0] ev_code,
      input logic [31:0] ev_value, input bit typed = 1'b0,
      input teas_pkg::job_t want = '0);
    stim_row_t row;
    row          = '0;
    row.kind     = ROW_EVENT;
    row.ev_type  = ev_type;
    row.ev_code  = ev_code;
    row.ev_value = ev_value;
    row.typed    = typed;
    row.want     = want;
    stim_table.push_back(row);
  endfunction

  function automatic void add_config(input logic [teas_pkg::COORD_BITS-1:0] sw, sh, tw, th,
      input logic [1:0] rot);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CONFIG;
    row.sw   = sw;
    row.sh   = sh;
    row.tw   = tw;
    row.th   = th;
    row.rot  = rot;
    stim_table.push_back(row);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance, valid still high.
  task automatic send_event(input logic [4:0] ev_type, input logic [9:0] ev_code,
      input logic [31:0] ev_value, input bit typed = 1'b0,
      input teas_pkg::job_t want = '0);
    int unsigned    gap;
    teas_pkg::job_t res;
    bit             got;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    event_type_i  <= ev_type;
    event_code_i  <= ev_code;
    event_value_i <= ev_value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    got = touch_predict(ev_type, ev_code, ev_value, res);
    if (typed) pending_samples.push_back(want);
    else if (got) pending_samples.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input logic [teas_pkg::COORD_BITS-1:0] sw, sh, tw, th,
      input logic [1:0] rot);
    logic [teas_pkg::COORD_BITS-1:0] vals [5];
    logic [teas_pkg::CFG_IDX_W-1:0]  idx [5];
    vals = '{sw, sh, tw, th, {14'd0, rot}};
    idx  = '{teas_pkg::REG_SCREEN_W, teas_pkg::REG_SCREEN_H, teas_pkg::REG_TOUCH_W,
             teas_pkg::REG_TOUCH_H, teas_pkg::REG_ROTATE};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[i])
        teas_pkg::REG_SCREEN_W: scr_w = vals[i];
        teas_pkg::REG_SCREEN_H: scr_h = vals[i];
        teas_pkg::REG_TOUCH_W:  tch_w = vals[i];
        teas_pkg::REG_TOUCH_H:  tch_h = vals[i];
        teas_pkg::REG_ROTATE:   rot_mode = vals[i][1:0];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly complete touches with random content; the rest are broken sequences and noise.
  task automatic send_gesture();
    logic [9:0]  order [3];
    logic [9:0]  tmp;
    logic [9:0]  code;
    logic [31:0] value;
    int unsigned r, k;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      repeat ($urandom_range(1, 3)) begin
        send_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd1);
        order = '{teas_pkg::AXIS_X_CODE, teas_pkg::AXIS_Y_CODE, teas_pkg::AXIS_P_CODE};
        for (int j = 2; j > 0; j--) begin
          k = $urandom_range(0, j);
          tmp = order[j];
          order[j] = order[k];
          order[k] = tmp;
        end
        for (int j = 0; j < 3; j++) begin
          send_event(teas_pkg::EV_TYPE_ABS, order[j], axis_value(order[j]));
          if ($urandom_range(0, 7) == 0)
            send_event(teas_pkg::EV_TYPE_ABS, order[j], axis_value(order[j]));
        end
      end
      if ($urandom_range(0, 4) != 0)
        send_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd0);
    end else if (r < 8) begin
      if ($urandom_range(0, 1) == 1)
        send_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd1);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0: code = teas_pkg::AXIS_X_CODE;
          1: code = teas_pkg::AXIS_Y_CODE;
          default: code = teas_pkg::AXIS_P_CODE;
        endcase
        case ($urandom_range(0, 3))
          0: value = 32'd0;
          1: value = {1'b1, 31'($urandom)};
          default: value = axis_value(code);
        endcase
        send_event(teas_pkg::EV_TYPE_ABS, code, value);
      end
      if ($urandom_range(0, 2) == 0)
        send_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, $urandom_range(2, 9));
      if ($urandom_range(0, 1) == 1)
        send_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd0);
    end else begin
      repeat ($urandom_range(1, 4))
        send_event(5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)), $urandom);
    end
  endtask

  always @(posedge clk_i) begin : check_output
    teas_pkg::job_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("unexpected word: x=%0d y=%0d p=%0d kind=%0d",
                   x_out_o, y_out_o, pressure_out_o, sample_kind_o);
      end else begin
        want = pending_samples.pop_front();
        if (x_out_o !== want.x || y_out_o !== want.y ||
            pressure_out_o !== want.pressure || sample_kind_o !== want.kind) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display({"word mismatch: expected x=%0d y=%0d p=%0d kind=%0d, ",
                      "got x=%0d y=%0d p=%0d kind=%0d"},
                     want.x, want.y, want.pressure, want.kind,
                     x_out_o, y_out_o, pressure_out_o, sample_kind_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("tb_touch_event_assembler_scaler failed");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the block backs up.
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
  end

  initial begin
    stim_row_t                       row;
    logic [teas_pkg::COORD_BITS-1:0] sw, sh, tw, th;
    logic [1:0]                      rot;
    int unsigned                     target;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    event_type_i  = '0;
    event_code_i  = '0;
    event_value_i = '0;
    idle_cycles   = 0;
    n_mismatch    = 0;
    n_effective   = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    scr_w         = teas_pkg::RST_SCREEN_W;
    scr_h         = teas_pkg::RST_SCREEN_H;
    tch_w         = teas_pkg::RST_TOUCH_W;
    tch_h         = teas_pkg::RST_TOUCH_H;
    rot_mode      = teas_pkg::ROTATE_NONE;
    seen          = '0;
    lat_x         = '0;
    lat_y         = '0;
    lat_p         = '0;

    // A release with nothing latched reports zeros.
    add_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd0, 1'b1,
              teas_pkg::job_t'{16'd0, 16'd0, 16'd0, teas_pkg::KIND_RELEASE});
    add_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd1);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_X_CODE, 32'h7FFF_FFFF);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_Y_CODE, 32'd0);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_Y_CODE, 32'h8000_0000);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_Y_CODE, 32'd300);
    add_event(EV_TYPE_SYN, teas_pkg::AXIS_X_CODE, 32'd5);
    add_event(teas_pkg::EV_TYPE_ABS, AXIS_UNUSED_CODE, 32'd7);
    add_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd2);
    add_event(5'h1F, 10'h3FF, 32'hFFFF_FFFF);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_P_CODE, 32'h0001_0000);
    add_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd0);
    // Equal sizes bypass scaling, so saturated values come out unchanged.
    add_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, teas_pkg::ROTATE_NONE);
    add_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd1);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_X_CODE, 32'h0001_0000);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_Y_CODE, 32'h0000_FFFF);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_P_CODE, 32'h7FFF_FFFF, 1'b1,
              teas_pkg::job_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, teas_pkg::KIND_SAMPLE});
    add_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd0, 1'b1,
              teas_pkg::job_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, teas_pkg::KIND_RELEASE});
    add_config(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, teas_pkg::ROTATE_MIRROR);
    add_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd1);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_X_CODE, 32'd1);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_Y_CODE, 32'h0000_FFFF);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_P_CODE, 32'd2);
    // Zero touch width leaves X unscaled; zero screen height removes no fraction from Y.
    add_config(16'd0, 16'd0, 16'd0, 16'd100, teas_pkg::ROTATE_NONE);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_X_CODE, 32'd1234);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_Y_CODE, 32'd77);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_P_CODE, 32'd9);
    add_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd1);
    add_config(16'hFFFF, 16'hFFFF, 16'd2, 16'd3, ROTATE_SPARE3);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_X_CODE, 32'h0000_FFFF);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_Y_CODE, 32'h0000_FFFF);
    add_event(teas_pkg::EV_TYPE_ABS, teas_pkg::AXIS_P_CODE, 32'h0000_FFFF);
    add_event(teas_pkg::EV_TYPE_KEY, teas_pkg::TOUCH_KEY_CODE, 32'd1);

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_table[n]) begin
      row = stim_table[n];
      if (row.kind == ROW_CONFIG) begin
        drain_block();
        configure(row.sw, row.sh, row.tw, row.th, row.rot);
      end else begin
        send_event(row.ev_type, row.ev_code, row.ev_value, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_block();
      case (ph)
        0: begin
          sw  = teas_pkg::RST_SCREEN_W;
          sh  = teas_pkg::RST_SCREEN_H;
          tw  = teas_pkg::RST_TOUCH_W;
          th  = teas_pkg::RST_TOUCH_H;
          rot = teas_pkg::ROTATE_NONE;
        end
        1: begin
          tw  = 16'($urandom_range(1, 4000));
          th  = 16'($urandom_range(1, 4000));
          sw  = 16'($urandom_range(32'(tw) + 1, 65535));
          sh  = 16'($urandom_range(32'(th) + 1, 65535));
          rot = 2'($urandom_range(0, 3));
        end
        2: begin
          tw  = 16'($urandom_range(2, 65535));
          th  = 16'($urandom_range(2, 65535));
          sw  = 16'($urandom_range(1, 32'(tw) - 1));
          sh  = 16'($urandom_range(1, 32'(th) - 1));
          rot = teas_pkg::ROTATE_MIRROR;
        end
        3: begin
          tw  = 16'($urandom_range(1, 65535));
          th  = 16'($urandom_range(1, 65535));
          sw  = tw;
          sh  = th;
          rot = 2'($urandom_range(0, 3));
        end
        4: begin
          tw    = 16'($urandom_range(1, 65535));
          th    = 16'($urandom_range(1, 65535));
          sw    = 16'($urandom_range(1, 65535));
          sh    = 16'($urandom_range(1, 65535));
          rot   = 2'($urandom_range(0, 3));
          quiet = 1'b1;
        end
        PRESSURE_PHASE: begin
          sw  = 16'd1;
          sh  = 16'hFFFF;
          tw  = 16'hFFFF;
          th  = 16'd1;
          rot = ROTATE_SPARE2;
        end
        6: begin
          tw  = 16'($urandom_range(1, 4));
          th  = 16'($urandom_range(1, 4));
          sw  = 16'($urandom_range(1, 65535));
          sh  = 16'($urandom_range(1, 65535));
          rot = ROTATE_SPARE3;
        end
        default: begin
          tw  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
          th  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
          sw  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
          sh  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
          rot = 2'($urandom_range(0, 3));
        end
      endcase
      configure(sw, sh, tw, th, rot);
      if (ph == PRESSURE_PHASE) hold_req = 1'b1;
      target = n_effective + ITEMS_PER_PHASE;
      while (n_effective < target) send_gesture();
      quiet = 1'b0;
    end

    drain_block();
    if (n_mismatch == 0 && pending_samples.size() == 0) begin
      $display("tb_touch_event_assembler_scaler passed");
    end else begin
      $display("tb_touch_event_assembler_scaler failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/teas_pkg.sv
rtl/teas_div.sv
rtl/teas_axis.sv
rtl/teas_fifo.sv
rtl/teas_front.sv
rtl/touch_event_assembler_scaler.sv
verif/tb_touch_event_assembler_scaler.sv
